FILE: rtl/slfp_pkg.sv
// Package for the sync/length frame parser.
// Holds the configuration and result record types, phase codes and reset values.
// No dependencies.
package slfp_pkg;

    localparam int TDATA_W    = 64;
    localparam int TUSER_W    = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [7:0]  SYNC_FIRST_RST    = 8'hAF;
    localparam logic [7:0]  SYNC_SECOND_RST   = 8'h20;
    localparam logic [7:0]  EXPECTED_TYPE_RST = 8'd5;
    localparam logic [15:0] MAX_LEN_RST       = 16'd2048;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_EXP_TYPE    = 2'd2,
        REG_MAX_LEN     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SYNC2  = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        HDR_TYPE   = 2'd0,
        HDR_SUB    = 2'd1,
        HDR_LEN_LO = 2'd2,
        HDR_LEN_HI = 2'd3
    } hdr_idx_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  expected_type;
        logic [15:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] payload_offset;
        logic [7:0]  hdr_type;
        logic [7:0]  sub_id;
        logic [15:0] hdr_len;
        logic        is_payload;
        logic        frame_end;
        logic        checksum_ok;
        logic        type_match;
        logic        length_error;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/slfp_front.sv
// Front end of the frame parser: sync hunt, header capture, payload and checksum tracking.
// Turns each accepted byte into at most one result record. Depends on slfp_pkg.
module slfp_front
    import slfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  check_a_reg, check_a_next;
    logic        seen_reg, seen_next;

    logic [15:0] len_full;
    logic        len_bad;
    logic        in_payload;
    hdr_idx_t    hdr_idx;

    assign len_full   = {rx_byte, len_reg[7:0]};
    assign len_bad    = len_full > cfg.max_len;
    assign in_payload = count_reg < len_reg;
    assign hdr_idx    = hdr_idx_t'(count_reg[1:0]);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.sync_first)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == cfg.sync_second) ? PH_HEADER : PH_HUNT;
                end
                PH_HEADER:
                begin
                    if (hdr_idx == HDR_LEN_HI)
                    begin
                        phase_next = len_bad ? PH_HUNT : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (!in_payload && seen_reg)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        sub_next     = sub_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        check_a_next = check_a_reg;
        seen_next    = seen_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.hdr_type = type_reg;
        res.sub_id   = sub_reg;
        res.hdr_len  = len_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                end
                PH_SYNC2:
                begin
                    if (rx_byte == cfg.sync_second)
                    begin
                        count_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    unique case (hdr_idx)
                        HDR_TYPE:   type_next = rx_byte;
                        HDR_SUB:    sub_next  = rx_byte;
                        HDR_LEN_LO: len_next  = {len_reg[15:8], rx_byte};
                        HDR_LEN_HI: len_next  = len_full;
                    endcase
                    if (hdr_idx != HDR_LEN_HI)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                    else
                    begin
                        count_next   = '0;
                        sum_a_next   = '0;
                        sum_b_next   = '0;
                        check_a_next = '0;
                        seen_next    = 1'b0;
                        if (len_bad)
                        begin
                            res_valid        = 1'b1;
                            res.hdr_len      = len_full;
                            res.length_error = 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (in_payload)
                    begin
                        sum_a_next         = sum_a_reg + rx_byte;
                        sum_b_next         = sum_b_reg + sum_a_next;
                        count_next         = count_reg + 16'd1;
                        res_valid          = 1'b1;
                        res.data_byte      = rx_byte;
                        res.payload_offset = count_reg;
                        res.is_payload     = 1'b1;
                    end
                    else if (!seen_reg)
                    begin
                        check_a_next = rx_byte;
                        seen_next    = 1'b1;
                    end
                    else
                    begin
                        count_next      = '0;
                        seen_next       = 1'b0;
                        res_valid       = 1'b1;
                        res.frame_end   = 1'b1;
                        res.checksum_ok = (check_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
                        res.type_match  = res.checksum_ok && (type_reg == cfg.expected_type);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            sub_reg     <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            check_a_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            sub_reg     <= sub_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            check_a_reg <= check_a_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

FILE: rtl/slfp_fifo.sv
// Short result queue between the parser front end and the output stage.
// Holds result records in a small register array. Depends on slfp_pkg.
module slfp_fifo
    import slfp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    input  logic pop,
    output res_t pop_data,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/slfp_back.sv
// Output stage of the frame parser: drains the result queue into the master stream register.
// Packs each result record onto tdata, tuser and tlast. Depends on slfp_pkg.
module slfp_back
    import slfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  res_t               q_data,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,
    output logic               m_axis_tlast
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign q_pop = !q_empty && (!valid_reg || m_axis_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = data_reg.frame_end;
    assign m_axis_tuser  = {data_reg.length_error, data_reg.is_payload};
    assign m_axis_tdata  = {6'b0, data_reg.type_match, data_reg.checksum_ok,
                            data_reg.hdr_len, data_reg.sub_id, data_reg.hdr_type,
                            data_reg.payload_offset, data_reg.data_byte};

endmodule

FILE: rtl/sync_length_frame_parser_top.sv
// Channel     | Dir | Contents
// s_axis      | in  | one received byte per transaction
// m_axis      | out | payload byte, length error or frame end result
// apb         | in  | sync bytes, expected type, maximum payload length
//
// Takes one byte per cycle unless the result queue is full; the parser state is registered.
// Each result is queued, then loaded into the output register, and so shows on m_axis.
// Reset clears all control state at once, so the block takes bytes as soon as reset ends.
// A stalled output fills the result queue and output register; s_axis_tready drops when full.
//
// Top level of the sync/length frame parser. Depends on slfp_pkg, slfp_front,
// slfp_fifo and slfp_back.
module sync_length_frame_parser_top
    import slfp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] data_byte, [23:8] payload_offset, [31:24] hdr_type, [39:32] sub_id,
    // [55:40] hdr_len, [56] checksum_ok, [57] type_match, [63:58] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,  // [0] is_payload, [1] length_error
    output logic               m_axis_tlast,  // frame_end
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     take;
    logic     res_valid;
    res_t     res;
    logic     q_full, q_empty, q_pop;
    res_t     q_data;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SYNC_FIRST:  cfg_next.sync_first    = pwdata[7:0];
                REG_SYNC_SECOND: cfg_next.sync_second   = pwdata[7:0];
                REG_EXP_TYPE:    cfg_next.expected_type = pwdata[7:0];
                REG_MAX_LEN:     cfg_next.max_len       = pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SYNC_FIRST:  prdata = {24'b0, cfg_reg.sync_first};
            REG_SYNC_SECOND: prdata = {24'b0, cfg_reg.sync_second};
            REG_EXP_TYPE:    prdata = {24'b0, cfg_reg.expected_type};
            REG_MAX_LEN:     prdata = {16'b0, cfg_reg.max_len};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= SYNC_FIRST_RST;
            cfg_reg.sync_second   <= SYNC_SECOND_RST;
            cfg_reg.expected_type <= EXPECTED_TYPE_RST;
            cfg_reg.max_len       <= MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    slfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (s_axis_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    slfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    slfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/slfp_checker.sv
// Port-level checker for the sync/length frame parser, bound to the top level.
// Depends on slfp_pkg and sync_length_frame_parser_top.
module slfp_checker
    import slfp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [TUSER_W-1:0] m_axis_tuser,
    input logic               m_axis_tlast
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output transaction dropped while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == '0)
        else $error("Frame end result also flagged as payload or length error.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[23:0] == '0 && m_axis_tdata[57:56] == '0 && !m_axis_tuser[0])
        else $error("Length error result carries payload or checksum flags.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[57] |-> m_axis_tdata[56] && m_axis_tlast)
        else $error("Type match without a good checksum at frame end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:8] < m_axis_tdata[55:40])
        else $error("Payload offset not below the header length.");

endmodule

bind sync_length_frame_parser_top slfp_checker u_slfp_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_frame_parser_top: drives serial bytes on s_axis,
// programs the APB registers and checks every m_axis transaction against a frame predictor.
// Depends on slfp_pkg and the parser RTL.
module testbench;
    import slfp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_CYCLES = 8;
    localparam int PHASE_BYTES  = 290;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        res_t       fixed;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;
    logic               m_axis_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cfg_t        cur_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, EXPECTED_TYPE_RST, MAX_LEN_RST};
    phase_t      frm_phase = PH_HUNT;
    logic [15:0] frm_count = '0;
    logic [15:0] frm_len = '0;
    logic [7:0]  frm_type = '0;
    logic [7:0]  frm_sub = '0;
    logic [7:0]  fl_a = '0;
    logic [7:0]  fl_b = '0;
    logic [7:0]  rx_ck_a = '0;
    logic        ck_a_seen = 1'b0;

    res_t     pending_results[$];
    dir_row_t directed_rows[26];
    int       err_count = 0;
    int       bytes_sent = 0;
    int       cycle_count = 0;
    bit       steady_tx = 1'b0;
    bit       steady_rx = 1'b0;
    bit       squeeze_go = 1'b0;
    logic     hold_off = 1'b0;

    sync_length_frame_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_gap(input bit steady);
        if (steady || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic res_t fixed_result(input logic [7:0] ty, input logic [7:0] sub,
                                          input logic [15:0] len, input logic ck,
                                          input logic tm, input logic lerr);
        res_t r;
        r = '0;
        r.hdr_type     = ty;
        r.sub_id       = sub;
        r.hdr_len      = len;
        r.frame_end    = !lerr;
        r.checksum_ok  = ck;
        r.type_match   = tm;
        r.length_error = lerr;
        return r;
    endfunction

    function automatic logic parse_byte(input logic [7:0] b, output res_t r);
        logic hit;
        hit = 1'b0;
        r = '0;
        case (frm_phase)
            PH_HUNT:
            begin
                if (b == cur_cfg.sync_first)
                    frm_phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (b == cur_cfg.sync_second)
                begin
                    frm_phase = PH_HEADER;
                    frm_count = '0;
                end
                else
                    frm_phase = PH_HUNT;
            end
            PH_HEADER:
            begin
                case (hdr_idx_t'(frm_count[1:0]))
                    HDR_TYPE:   frm_type = b;
                    HDR_SUB:    frm_sub = b;
                    HDR_LEN_LO: frm_len[7:0] = b;
                    HDR_LEN_HI: frm_len[15:8] = b;
                endcase
                if (hdr_idx_t'(frm_count[1:0]) != HDR_LEN_HI)
                    frm_count = frm_count + 16'd1;
                else if (frm_len > cur_cfg.max_len)
                begin
                    frm_phase = PH_HUNT;
                    frm_count = '0;
                    r.length_error = 1'b1;
                    hit = 1'b1;
                end
                else
                begin
                    frm_phase = PH_BODY;
                    frm_count = '0;
                    fl_a = '0;
                    fl_b = '0;
                    rx_ck_a = '0;
                    ck_a_seen = 1'b0;
                end
            end
            PH_BODY:
            begin
                if (frm_count < frm_len)
                begin
                    r.data_byte = b;
                    r.payload_offset = frm_count;
                    r.is_payload = 1'b1;
                    fl_a = fl_a + b;
                    fl_b = fl_b + fl_a;
                    frm_count = frm_count + 16'd1;
                    hit = 1'b1;
                end
                else if (!ck_a_seen)
                begin
                    rx_ck_a = b;
                    ck_a_seen = 1'b1;
                end
                else
                begin
                    r.frame_end = 1'b1;
                    r.checksum_ok = (rx_ck_a == fl_a) && (b == fl_b);
                    r.type_match = r.checksum_ok && (frm_type == cur_cfg.expected_type);
                    frm_phase = PH_HUNT;
                    frm_count = '0;
                    ck_a_seen = 1'b0;
                    hit = 1'b1;
                end
            end
        endcase
        r.hdr_type = frm_type;
        r.sub_id = frm_sub;
        r.hdr_len = frm_len;
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input res_t fixed = '0);
        int   gap;
        res_t r;
        logic hit;
        gap = draw_gap(steady_tx);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit = parse_byte(b, r);
        if (typed)
            pending_results.push_back(fixed);
        else if (hit)
            pending_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SYNC_FIRST:  cur_cfg.sync_first = val[7:0];
            REG_SYNC_SECOND: cur_cfg.sync_second = val[7:0];
            REG_EXP_TYPE:    cur_cfg.expected_type = val[7:0];
            REG_MAX_LEN:     cur_cfg.max_len = val[15:0];
        endcase
    endtask

    task automatic configure(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [7:0] et, input logic [15:0] ml);
        write_reg(REG_SYNC_FIRST, {24'd0, sf});
        write_reg(REG_SYNC_SECOND, {24'd0, ss});
        write_reg(REG_EXP_TYPE, {24'd0, et});
        write_reg(REG_MAX_LEN, {16'd0, ml});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame();
        int          kind;
        int          room;
        int          len_i;
        logic [15:0] len;
        logic [7:0]  nb;
        logic [7:0]  sa;
        logic [7:0]  sb;
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            repeat ($urandom_range(1, 6))
            begin
                do
                    nb = 8'($urandom_range(0, 255));
                while (nb == cur_cfg.sync_first);
                send_byte(nb);
            end
        end
        else if (kind >= 80)
        begin
            nb = 8'($urandom_range(0, 255));
            if (nb == cur_cfg.sync_second)
                nb = nb + 8'd1;
            send_byte(cur_cfg.sync_first);
            send_byte(nb);
        end
        else if (kind >= 70 && cur_cfg.max_len != 16'hFFFF)
        begin
            room = 65535 - int'(cur_cfg.max_len) - 1;
            len_i = int'(cur_cfg.max_len) + 1
                    + int'($urandom_range(0, room < 200 ? room : 200));
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : len_i[15:0];
            send_byte(cur_cfg.sync_first);
            send_byte(cur_cfg.sync_second);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(len[7:0]);
            send_byte(len[15:8]);
        end
        else
        begin
            len_i = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 60))
                                                 : int'($urandom_range(0, 12));
            if (len_i > int'(cur_cfg.max_len))
                len_i = int'(cur_cfg.max_len);
            len = len_i[15:0];
            send_byte(cur_cfg.sync_first);
            send_byte(cur_cfg.sync_second);
            send_byte($urandom_range(0, 1) ? cur_cfg.expected_type : 8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(len[7:0]);
            send_byte(len[15:8]);
            sa = '0;
            sb = '0;
            for (int i = 0; i < len_i; i++)
            begin
                nb = 8'($urandom_range(0, 255));
                sa = sa + nb;
                sb = sb + sa;
                send_byte(nb);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1))
                    sa = sa ^ 8'($urandom_range(1, 255));
                else
                    sb = sb ^ 8'($urandom_range(1, 255));
            end
            send_byte(sa);
            send_byte(sb);
        end
    endtask

    task automatic run_phase();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
            send_frame();
        drain();
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("transaction with nothing pending", m_axis_tdata, '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.data_byte)
                    report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
                if (m_axis_tdata[23:8] !== want.payload_offset)
                    report_mismatch("payload_offset", m_axis_tdata[23:8], want.payload_offset);
                if (m_axis_tdata[31:24] !== want.hdr_type)
                    report_mismatch("hdr_type", m_axis_tdata[31:24], want.hdr_type);
                if (m_axis_tdata[39:32] !== want.sub_id)
                    report_mismatch("sub_id", m_axis_tdata[39:32], want.sub_id);
                if (m_axis_tdata[55:40] !== want.hdr_len)
                    report_mismatch("hdr_len", m_axis_tdata[55:40], want.hdr_len);
                if (m_axis_tuser[0] !== want.is_payload)
                    report_mismatch("is_payload", m_axis_tuser[0], want.is_payload);
                if (m_axis_tlast !== want.frame_end)
                    report_mismatch("frame_end", m_axis_tlast, want.frame_end);
                if (m_axis_tdata[56] !== want.checksum_ok)
                    report_mismatch("checksum_ok", m_axis_tdata[56], want.checksum_ok);
                if (m_axis_tdata[57] !== want.type_match)
                    report_mismatch("type_match", m_axis_tdata[57], want.type_match);
                if (m_axis_tuser[1] !== want.length_error)
                    report_mismatch("length_error", m_axis_tuser[1], want.length_error);
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        forever
        begin
            stall = draw_gap(steady_rx);
            if (stall > 0 || hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // The sink is held off for a long stretch while bytes keep arriving, so the block backs up.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows = '{
            '{8'hAF, 1'b0, '0},
            '{8'h21, 1'b0, '0},
            '{8'hAF, 1'b0, '0},
            '{8'h20, 1'b0, '0},
            '{8'h05, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h01, 1'b0, '0},
            '{8'h08, 1'b1, fixed_result(8'h05, 8'hFF, 16'h0801, 1'b0, 1'b0, 1'b1)},
            '{8'hAF, 1'b0, '0},
            '{8'h20, 1'b0, '0},
            '{8'h05, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, fixed_result(8'h05, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b0)},
            '{8'hAF, 1'b0, '0},
            '{8'h20, 1'b0, '0},
            '{8'h07, 1'b0, '0},
            '{8'h01, 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h80, 1'b0, '0},
            '{8'h7F, 1'b0, '0},
            '{8'h7E, 1'b1, fixed_result(8'h07, 8'h01, 16'h0002, 1'b1, 1'b0, 1'b0)}
        };
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].fixed);
        drain();

        configure(8'h00, 8'hFF, 8'h00, 16'h0000);
        run_phase();
        configure(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        run_phase();
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(1, 64)));
        run_phase();
        configure(SYNC_FIRST_RST, SYNC_SECOND_RST, EXPECTED_TYPE_RST, 16'd16);
        steady_tx = 1'b1;
        squeeze_go = 1'b1;
        run_phase();
        steady_rx = 1'b1;
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'd8);
        run_phase();
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        run_phase();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/slfp_pkg.sv
rtl/slfp_front.sv
rtl/slfp_fifo.sv
rtl/slfp_back.sv
rtl/sync_length_frame_parser_top.sv
rtl/slfp_checker.sv
test/testbench.sv
